### rtl/dpc_pkg.sv
`default_nettype none

package dpc_pkg;

  // field widths
  localparam int BIN_W      = 12;
  localparam int INT_W      = 24;
  localparam int SUM_W      = 40;
  localparam int CNT_W      = 20;
  localparam int RATIO_W    = 8;
  localparam int PROD_W     = SUM_W + RATIO_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // profile and image limits
  localparam int              MAX_BINS   = 4096;
  localparam longint unsigned MAX_IMAGES = 64'd1048576;
  localparam longint unsigned CNT_SPAN   = 64'd1 << CNT_W;
  localparam longint unsigned IMG_WRAP   = (MAX_IMAGES < CNT_SPAN) ? MAX_IMAGES : CNT_SPAN;

  // register reset values
  localparam logic [BIN_W-1:0]   WATER_FIRST_RST = 12'd0;
  localparam logic [BIN_W-1:0]   WATER_LAST_RST  = 12'd4095;
  localparam logic [BIN_W-1:0]   ICE_FIRST_RST   = 12'd0;
  localparam logic [BIN_W-1:0]   ICE_LAST_RST    = 12'd0;
  localparam logic [SUM_W-1:0]   THRESHOLD_RST   = 40'd100000;
  localparam logic [RATIO_W-1:0] RATIO_RST       = 8'd10;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WATER_FIRST = 3'd0,
    CFG_WATER_LAST  = 3'd1,
    CFG_ICE_FIRST   = 3'd2,
    CFG_ICE_LAST    = 3'd3,
    CFG_THRESHOLD   = 3'd4,
    CFG_RATIO       = 3'd5
  } cfg_idx_t;

  // image classes
  typedef enum logic [1:0] {
    CLASS_WATER      = 2'd0,
    CLASS_BACKGROUND = 2'd1,
    CLASS_ICE        = 2'd2
  } class_t;

  typedef struct packed {
    logic [BIN_W-1:0]   water_first;
    logic [BIN_W-1:0]   water_last;
    logic [BIN_W-1:0]   ice_first;
    logic [BIN_W-1:0]   ice_last;
    logic [SUM_W-1:0]   threshold;
    logic [RATIO_W-1:0] ratio;
  } cfg_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [INT_W-1:0] intensity;
    logic             last_bin;
  } bin_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] water_sum;
    logic [SUM_W-1:0] ice_sum;
  } sums_t;

  typedef struct packed {
    class_t           image_class;
    logic [SUM_W-1:0] water_integral;
    logic [SUM_W-1:0] ice_integral;
    logic [CNT_W-1:0] image_number;
    logic [CNT_W-1:0] water_images;
    logic [CNT_W-1:0] background_images;
    logic [CNT_W-1:0] ice_images;
  } result_t;

endpackage

`default_nettype wire

### rtl/dpc_ifs.sv
`default_nettype none

// profile bin channel
interface dpc_in_if import dpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] bin_index;
  logic [INT_W-1:0] intensity;
  logic             last_bin;

  modport source (output valid, bin_index, intensity, last_bin, input ready);
  modport sink   (input valid, bin_index, intensity, last_bin, output ready);
endinterface

// image result channel
interface dpc_out_if import dpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       image_class;
  logic [SUM_W-1:0] water_integral;
  logic [SUM_W-1:0] ice_integral;
  logic [CNT_W-1:0] image_number;
  logic [CNT_W-1:0] water_images;
  logic [CNT_W-1:0] background_images;
  logic [CNT_W-1:0] ice_images;

  modport source (output valid, image_class, water_integral, ice_integral, image_number,
                  water_images, background_images, ice_images, input ready);
  modport sink   (input valid, image_class, water_integral, ice_integral, image_number,
                  water_images, background_images, ice_images, output ready);
endinterface

// register write channel
interface dpc_cfg_if import dpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/dpc_cfg_regs.sv
`default_nettype none

module dpc_cfg_regs import dpc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_valid,
  output logic                       wr_ready,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  // register file, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.water_first <= WATER_FIRST_RST;
      cfg_r.water_last  <= WATER_LAST_RST;
      cfg_r.ice_first   <= ICE_FIRST_RST;
      cfg_r.ice_last    <= ICE_LAST_RST;
      cfg_r.threshold   <= THRESHOLD_RST;
      cfg_r.ratio       <= RATIO_RST;
    end else if (wr_valid) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_WATER_FIRST: cfg_r.water_first <= wr_data[BIN_W-1:0];
        CFG_WATER_LAST:  cfg_r.water_last  <= wr_data[BIN_W-1:0];
        CFG_ICE_FIRST:   cfg_r.ice_first   <= wr_data[BIN_W-1:0];
        CFG_ICE_LAST:    cfg_r.ice_last    <= wr_data[BIN_W-1:0];
        CFG_THRESHOLD:   cfg_r.threshold   <= wr_data[SUM_W-1:0];
        CFG_RATIO:       cfg_r.ratio       <= wr_data[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/dpc_accum.sv
`default_nettype none

module dpc_accum import dpc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bin_req_t in_req,
  output logic          sums_valid,
  input  wire logic     sums_ready,
  output sums_t         sums
);

  logic             s0_v_r;
  bin_req_t         req_r;
  logic [SUM_W-1:0] water_sum_r, ice_sum_r;
  logic [SUM_W-1:0] water_nxt, ice_nxt;
  logic             fin_v_r;
  sums_t            fin_r;
  logic             fin_free, s0_take, in_range, water_hit, ice_hit;
  logic [SUM_W:0]   water_add, ice_add;

  // request in stage 0 leaves when it is a plain bin or the final stage has room
  assign fin_free = !fin_v_r || sums_ready;
  assign s0_take  = s0_v_r && (!req_r.last_bin || fin_free);
  assign in_ready = !s0_v_r || s0_take;

  // window hits
  assign in_range  = (32'(req_r.bin_index) < MAX_BINS);
  assign water_hit = in_range && (req_r.bin_index >= cfg.water_first) &&
                     (req_r.bin_index <= cfg.water_last);
  assign ice_hit   = in_range && (req_r.bin_index >= cfg.ice_first) &&
                     (req_r.bin_index <= cfg.ice_last);

  // saturating sums including this bin
  always_comb begin
    water_add = {1'b0, water_sum_r} + (SUM_W+1)'(water_hit ? req_r.intensity : '0);
    ice_add   = {1'b0, ice_sum_r} + (SUM_W+1)'(ice_hit ? req_r.intensity : '0);
    water_nxt = water_add[SUM_W] ? {SUM_W{1'b1}} : water_add[SUM_W-1:0];
    ice_nxt   = ice_add[SUM_W] ? {SUM_W{1'b1}} : ice_add[SUM_W-1:0];
  end

  // control and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      fin_v_r     <= 1'b0;
      water_sum_r <= '0;
      ice_sum_r   <= '0;
    end else begin
      if (in_ready) begin
        s0_v_r <= in_valid;
      end
      if (fin_free) begin
        fin_v_r <= s0_take && req_r.last_bin;
      end
      if (s0_take) begin
        water_sum_r <= req_r.last_bin ? '0 : water_nxt;
        ice_sum_r   <= req_r.last_bin ? '0 : ice_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready) begin
      req_r <= in_req;
    end
    if (fin_free && s0_take && req_r.last_bin) begin
      fin_r.water_sum <= water_nxt;
      fin_r.ice_sum   <= ice_nxt;
    end
  end

  assign sums_valid = fin_v_r;
  assign sums       = fin_r;

endmodule

`default_nettype wire

### rtl/dpc_classify.sv
`default_nettype none

module dpc_classify import dpc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  sums_valid,
  output logic       sums_ready,
  input  wire sums_t sums,
  output logic       res_valid,
  input  wire logic  res_ready,
  output result_t    res
);

  logic              p_v_r, out_v_r;
  logic              p_free, o_free, p_take;
  logic [SUM_W-1:0]  p_water_r, p_ice_r;
  logic [PROD_W-1:0] p_scaled_r;
  logic              p_above_r;
  logic [CNT_W-1:0]  img_r, water_cnt_r, bg_cnt_r, ice_cnt_r;
  logic [CNT_W-1:0]  img_nxt, water_cnt_nxt, bg_cnt_nxt, ice_cnt_nxt;
  class_t            cls;
  logic [PROD_W-1:0] water_ext;
  result_t           res_r;

  assign o_free     = !out_v_r || res_ready;
  assign p_free     = !p_v_r || o_free;
  assign p_take     = p_v_r && o_free;
  assign sums_ready = p_free;

  // class decision against the scaled ice sum
  assign water_ext = PROD_W'(p_water_r);
  always_comb begin
    if (p_above_r && (water_ext > p_scaled_r)) begin
      cls = CLASS_WATER;
    end else if (p_above_r && (water_ext < p_scaled_r)) begin
      cls = CLASS_ICE;
    end else begin
      cls = CLASS_BACKGROUND;
    end
  end

  // saturating class counts and wrapping image index
  always_comb begin
    water_cnt_nxt = water_cnt_r;
    bg_cnt_nxt    = bg_cnt_r;
    ice_cnt_nxt   = ice_cnt_r;
    case (cls)
      CLASS_WATER:      water_cnt_nxt = (&water_cnt_r) ? water_cnt_r : water_cnt_r + 1'b1;
      CLASS_ICE:        ice_cnt_nxt   = (&ice_cnt_r) ? ice_cnt_r : ice_cnt_r + 1'b1;
      default:          bg_cnt_nxt    = (&bg_cnt_r) ? bg_cnt_r : bg_cnt_r + 1'b1;
    endcase
    img_nxt = ((64'(img_r) + 64'd1) >= IMG_WRAP) ? '0 : img_r + 1'b1;
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r       <= 1'b0;
      out_v_r     <= 1'b0;
      img_r       <= '0;
      water_cnt_r <= '0;
      bg_cnt_r    <= '0;
      ice_cnt_r   <= '0;
    end else begin
      if (p_free) begin
        p_v_r <= sums_valid;
      end
      if (o_free) begin
        out_v_r <= p_v_r;
      end
      if (p_take) begin
        img_r       <= img_nxt;
        water_cnt_r <= water_cnt_nxt;
        bg_cnt_r    <= bg_cnt_nxt;
        ice_cnt_r   <= ice_cnt_nxt;
      end
    end
  end

  // product stage and result register
  always_ff @(posedge clk) begin
    if (p_free) begin
      p_water_r  <= sums.water_sum;
      p_ice_r    <= sums.ice_sum;
      p_scaled_r <= PROD_W'(sums.ice_sum) * PROD_W'(cfg.ratio);
      p_above_r  <= sums.water_sum > cfg.threshold;
    end
    if (p_take) begin
      res_r.image_class       <= cls;
      res_r.water_integral    <= p_water_r;
      res_r.ice_integral      <= p_ice_r;
      res_r.image_number      <= img_r;
      res_r.water_images      <= water_cnt_nxt;
      res_r.background_images <= bg_cnt_nxt;
      res_r.ice_images        <= ice_cnt_nxt;
    end
  end

  assign res_valid = out_v_r;
  assign res       = res_r;

endmodule

`default_nettype wire

### rtl/diffraction_profile_classifier_unit.sv
// path of a result: stage 0, final sums stage, product stage, result register
// throughput: one bin per cycle; stalls only on a bin marked last, when the
// result register is held by the sink and the stages behind it are full
// reset: rst_n synchronous active low clears sums, counters, image index and
// stage valids, and loads the register defaults
`default_nettype none

module diffraction_profile_classifier_unit import dpc_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  dpc_in_if.sink     in_bus,
  dpc_out_if.source  out_bus,
  dpc_cfg_if.sink    cfg_bus
);

  cfg_t     cfg;
  bin_req_t in_req;
  logic     sums_valid, sums_ready;
  sums_t    sums;
  result_t  res;

  // configuration registers
  dpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_bus.valid),
    .wr_ready (cfg_bus.ready),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .cfg      (cfg)
  );

  // windowed accumulation
  assign in_req.bin_index = in_bus.bin_index;
  assign in_req.intensity = in_bus.intensity;
  assign in_req.last_bin  = in_bus.last_bin;

  dpc_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_req     (in_req),
    .sums_valid (sums_valid),
    .sums_ready (sums_ready),
    .sums       (sums)
  );

  // classification and counts
  dpc_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .sums_valid (sums_valid),
    .sums_ready (sums_ready),
    .sums       (sums),
    .res_valid  (out_bus.valid),
    .res_ready  (out_bus.ready),
    .res        (res)
  );

  assign out_bus.image_class       = res.image_class;
  assign out_bus.water_integral    = res.water_integral;
  assign out_bus.ice_integral      = res.ice_integral;
  assign out_bus.image_number      = res.image_number;
  assign out_bus.water_images      = res.water_images;
  assign out_bus.background_images = res.background_images;
  assign out_bus.ice_images        = res.ice_images;

endmodule

`default_nettype wire
